@@ rtl/fmbq_pkg.sv @@
// Shared types and constants for the front/middle/back queue.
package fmbq_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned FILL_W   = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_MID   = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_MID    = 3'd4,
    OP_POP_BACK   = 3'd5
  } fmbq_op_t;

  // Shift command broadcast to every cell in the row.
  typedef struct packed {
    logic ins;  // open a slot at pos, shift the tail toward the back
    logic rem;  // close the slot at pos, shift the tail toward the front
  } fmbq_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_TREE
  } fmbq_state_t;

endpackage

@@ rtl/front_middle_back_queue_unit.sv @@
// Front/middle/back queue top level: row of slot cells, OR tree, control.
// Each accepted word passes through the registered OR tree, which gathers the removed
// word from the addressed slot, and then the output register; a new word is taken only
// once the last result has been loaded into the output register.
// Reset clears the count, the state machine and out_valid; slot contents stay
// undefined until written.
module front_middle_back_queue_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fmbq_pkg::OPCODE_W-1:0]   opcode,
  input  logic signed [fmbq_pkg::VALUE_W-1:0] push_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [fmbq_pkg::VALUE_W-1:0] pop_value,
  output logic                            was_empty,
  output logic                            overflow,
  output logic [fmbq_pkg::FILL_W-1:0]     fill_count
);
  import fmbq_pkg::*;

  localparam int unsigned IDXW  = $clog2(DEPTH);
  localparam int unsigned CNTW  = $clog2(DEPTH + 1);
  localparam int unsigned LOG   = $clog2(DEPTH);
  localparam int unsigned WALKW = $clog2(LOG + 1);

  fmbq_state_t state, state_next;

  logic [CNTW-1:0]  count, count_next;
  logic [WALKW-1:0] walk;
  logic             in_acc;
  logic             load_out;
  logic             is_push, is_pop;
  logic             full, empty;
  logic [CNTW-1:0]  pos_wide;
  logic [IDXW-1:0]  pos;
  fmbq_cmd_t        cmd;

  logic [DATA_WIDTH+VALUE_W-1:0] push_ext;
  logic [DATA_WIDTH-1:0]         word;

  logic [DATA_WIDTH-1:0]              cell_q [DEPTH];
  logic [DEPTH-1:0][DATA_WIDTH-1:0]   taps;
  logic [DATA_WIDTH-1:0]              root;
  logic [DATA_WIDTH+VALUE_W-1:0]      root_ext;

  // Result fields held while the tree settles.
  logic             use_tap;
  logic             empty_hit;
  logic             over_hit;
  logic [CNTW-1:0]  count_res;
  logic [CNTW+FILL_W-1:0] count_ext;

  assign in_acc   = in_valid & ~in_stall;
  assign full     = (count == CNTW'(DEPTH));
  assign empty    = (count == '0);
  assign push_ext = {{DATA_WIDTH{1'b0}}, push_value};
  assign word     = push_ext[DATA_WIDTH-1:0];

  // Decode opcode into a slot position.
  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    pos_wide = '0;
    case (opcode)
      OP_PUSH_FRONT: begin
        is_push = 1'b1;
      end
      OP_PUSH_MID: begin
        is_push  = 1'b1;
        pos_wide = count >> 1;
      end
      OP_PUSH_BACK: begin
        is_push  = 1'b1;
        pos_wide = count;
      end
      OP_POP_FRONT: begin
        is_pop = 1'b1;
      end
      OP_POP_MID: begin
        is_pop   = 1'b1;
        pos_wide = (count - CNTW'(1)) >> 1;
      end
      OP_POP_BACK: begin
        is_pop   = 1'b1;
        pos_wide = count - CNTW'(1);
      end
      default: begin
        is_push = 1'b0;
        is_pop  = 1'b0;
      end
    endcase
  end

  assign pos     = pos_wide[IDXW-1:0];
  assign cmd.ins = in_acc & is_push & ~full;
  assign cmd.rem = in_acc & is_pop & ~empty;

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNTW'(1);
    end else if (cmd.rem) begin
      count_next = count - CNTW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_q[i];
    end else begin : g_inner_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_inner_r
      assign right_w = cell_q[i+1];
    end
    fmbq_cell #(
      .INDEX      (i),
      .IDXW       (IDXW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (pos),
      .word  (word),
      .left  (left_w),
      .right (right_w),
      .value (cell_q[i]),
      .tap   (taps[i])
    );
  end

  fmbq_tree #(
    .LEAVES (DEPTH),
    .WIDTH  (DATA_WIDTH)
  ) u_tree (
    .clk     (clk),
    .load    (in_acc),
    .leaf_in (taps),
    .root    (root)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_TREE;
        end
      end
      ST_TREE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_TREE: begin
        load_out = (walk == WALKW'(LOG)) & (~out_valid | ~out_stall);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      walk      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (in_acc) begin
        walk <= '0;
      end else if (walk != WALKW'(LOG)) begin
        walk <= walk + WALKW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result fields of the word in flight.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      use_tap   <= cmd.rem;
      empty_hit <= is_pop & empty;
      over_hit  <= is_push & full;
      count_res <= count_next;
    end
  end

  assign root_ext  = {{VALUE_W{root[DATA_WIDTH-1]}}, root};
  assign count_ext = {{FILL_W{1'b0}}, count_res};

  always_ff @(posedge clk) begin
    if (load_out) begin
      pop_value  <= use_tap ? root_ext[VALUE_W-1:0] : '1;
      was_empty  <= empty_hit;
      overflow   <= over_hit;
      fill_count <= count_ext[FILL_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("queue count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!in_acc && !rst) |=> $stable(count))
    else $error("queue count moved without an accepted word");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(was_empty && overflow))
    else $error("empty and overflow flags raised together");

endmodule

@@ rtl/fmbq_cell.sv @@
// One queue slot: holds a word, takes the pushed or a neighbor's word.
module fmbq_cell #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned IDXW       = 4,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  fmbq_pkg::fmbq_cmd_t   cmd,
  input  logic [IDXW-1:0]       pos,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] value,
  output logic [DATA_WIDTH-1:0] tap
);
  import fmbq_pkg::*;

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(INDEX);

  logic [DATA_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    if (cmd.ins) begin
      if (MY_IDX > pos) begin
        value_next = left;
      end else if (MY_IDX == pos) begin
        value_next = word;
      end
    end else if (cmd.rem) begin
      if (MY_IDX >= pos) begin
        value_next = right;
      end
    end
  end

  // Offer the current word only when this slot is the one addressed.
  assign tap = (MY_IDX == pos) ? value : '0;

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ rtl/fmbq_tree.sv @@
// Registered OR tree that collects the one addressed slot word, one register level per tree level.
module fmbq_tree #(
  parameter int unsigned LEAVES = 16,
  parameter int unsigned WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [LEAVES-1:0][WIDTH-1:0]  leaf_in,
  output logic [WIDTH-1:0]              root
);
  import fmbq_pkg::*;

  localparam int unsigned LOG = $clog2(LEAVES);
  localparam int unsigned P   = 1 << LOG;

  logic [WIDTH-1:0] node [1:2*P-1];

  for (genvar k = 0; k < P; k++) begin : g_leaf
    if (k < LEAVES) begin : g_used
      always_ff @(posedge clk) begin
        if (load) begin
          node[P+k] <= leaf_in[k];
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node[P+k] <= '0;
      end
    end
  end

  for (genvar k = 1; k < P; k++) begin : g_node
    always_ff @(posedge clk) begin
      node[k] <= node[2*k] | node[2*k+1];
    end
  end

  assign root = node[1];

endmodule

@@ test/front_middle_back_queue_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench for the front/middle/back queue: directed and random words checked against a queue model.
module front_middle_back_queue_unit_test;
  import fmbq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;

  localparam logic [OPCODE_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_B = 3'd7;

  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;

  localparam int RANDOM_WORDS = 600;
  localparam int SEGMENT_LEN  = 30;
  localparam int HOLD_AT      = 150;
  localparam int LONG_HOLD    = 300;
  localparam int LATENCY      = 5;
  localparam int IDLE_LIMIT   = 3000;
  localparam int MAX_REPORTS  = 20;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  value;
    int                  gap;
    bit                  drain_first;
  } queued_word_t;

  typedef struct {
    logic [VALUE_W-1:0] pop_value;
    logic               was_empty;
    logic               overflow;
    logic [FILL_W-1:0]  fill_count;
  } word_result_t;

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  logic [OPCODE_W-1:0]        opcode     = '0;
  logic signed [VALUE_W-1:0]  push_value = '0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  logic signed [VALUE_W-1:0]  pop_value;
  logic                       was_empty;
  logic                       overflow;
  logic [FILL_W-1:0]          fill_count;

  front_middle_back_queue_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pop_value  (pop_value),
    .was_empty  (was_empty),
    .overflow   (overflow),
    .fill_count (fill_count)
  );

  always #5 clk = ~clk;

  // Queue model and pending traffic
  logic [VALUE_W-1:0] model_words[$];
  word_result_t       exp_results[$];
  queued_word_t       pend_words[$];

  queued_word_t next_word;
  bit           have_next = 1'b0;
  int           gap_left  = 0;
  bit           src_burst = 1'b0;

  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  int words_sent      = 0;
  int results_checked = 0;
  int idle_cycles     = 0;
  int fail_count      = 0;

  int sink_wait      = 0;
  bit sink_burst     = 1'b0;
  bit long_hold_done = 1'b0;

  int n_push = 0, n_pop = 0, n_full_drop = 0, n_empty_pop = 0, n_noop = 0, peak_fill = 0;

  function automatic word_result_t apply_word(logic [OPCODE_W-1:0] op,
                                              logic [VALUE_W-1:0] value);
    word_result_t r;
    int unsigned  pos;
    r.pop_value = '1;
    r.was_empty = 1'b0;
    r.overflow  = 1'b0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_MID, OP_PUSH_BACK: begin
        if (model_words.size() >= DEPTH) begin
          r.overflow = 1'b1;
          n_full_drop++;
        end else begin
          if (op == OP_PUSH_FRONT) pos = 0;
          else if (op == OP_PUSH_MID) pos = model_words.size() / 2;
          else pos = model_words.size();
          model_words.insert(pos, value);
          n_push++;
        end
      end
      OP_POP_FRONT, OP_POP_MID, OP_POP_BACK: begin
        if (model_words.size() == 0) begin
          r.was_empty = 1'b1;
          n_empty_pop++;
        end else begin
          if (op == OP_POP_FRONT) pos = 0;
          else if (op == OP_POP_MID) pos = (model_words.size() - 1) / 2;
          else pos = model_words.size() - 1;
          r.pop_value = model_words[pos];
          model_words.delete(pos);
          n_pop++;
        end
      end
      default: n_noop++;
    endcase
    r.fill_count = FILL_W'(model_words.size());
    if (model_words.size() > peak_fill) peak_fill = model_words.size();
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = VALUE_MIN;
      1:       v = VALUE_MAX;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_word(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value, bit drain);
    queued_word_t w;
    int           idx;
    idx = pend_words.size();
    w.op          = op;
    w.value       = value;
    w.drain_first = drain;
    // keep offering back to back around the long receiver hold
    if (src_burst || (idx >= HOLD_AT - 10 && idx < HOLD_AT + 60)) w.gap = 0;
    else w.gap = $urandom_range(0, 10);
    pend_words.insert(pend_words.size(), w);
  endtask

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    if (fail_count < MAX_REPORTS)
      $display("mismatch at result %0d: %s got %h expected %h",
               results_checked, what, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    word_result_t want;
    if (exp_results.size() == 0) begin
      report_mismatch("result with no word pending", pop_value, '0);
    end else begin
      want = exp_results.pop_front();
      if (pop_value !== want.pop_value)
        report_mismatch("pop_value", pop_value, want.pop_value);
      if (was_empty !== want.was_empty)
        report_mismatch("was_empty", 32'(was_empty), 32'(want.was_empty));
      if (overflow !== want.overflow)
        report_mismatch("overflow", 32'(overflow), 32'(want.overflow));
      if (fill_count !== want.fill_count)
        report_mismatch("fill_count", 32'(fill_count), 32'(want.fill_count));
    end
    results_checked++;
  endtask

  // Driver: present the next word on the falling edge once the last one is taken
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_taken)) begin
      if (!have_next && pend_words.size() > 0) begin
        next_word = pend_words.pop_front();
        have_next = 1'b1;
        gap_left  = next_word.gap;
      end
      if (have_next && gap_left == 0 &&
          (!next_word.drain_first || exp_results.size() == 0)) begin
        in_valid   <= 1'b1;
        opcode     <= next_word.op;
        push_value <= next_word.value;
        have_next  = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Receiver: stall for a random wait after each word taken, with one long hold to back up the block
  always @(negedge clk) begin
    if (!rst) begin
      if (!long_hold_done && words_sent >= HOLD_AT) begin
        sink_wait      = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (out_taken) begin
        if (results_checked % 40 == 0) sink_burst = ($urandom_range(0, 2) == 0);
        sink_wait = sink_burst ? 0 : $urandom_range(0, 10);
      end
      if (sink_wait > 0) begin
        out_stall <= 1'b1;
        sink_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: check results first, then predict the word taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      in_taken    <= 1'b0;
      out_taken   <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken  <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        exp_results.insert(exp_results.size(), apply_word(opcode, push_value));
        words_sent++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  value;
    int                  push_pct;
    int                  r;
    int                  total;

    // empty pops and unused opcodes
    add_word(OP_POP_FRONT, draw_value(), 1'b0);
    add_word(OP_POP_MID, draw_value(), 1'b0);
    add_word(OP_POP_BACK, draw_value(), 1'b0);
    add_word(OP_UNUSED_A, draw_value(), 1'b0);
    add_word(OP_UNUSED_B, draw_value(), 1'b0);
    // fill to the top, pushing at every position, with extreme values first
    for (int i = 0; i < DEPTH; i++) begin
      if (i % 3 == 0) op = OP_PUSH_FRONT;
      else if (i % 3 == 1) op = OP_PUSH_MID;
      else op = OP_PUSH_BACK;
      case (i)
        0:       value = VALUE_MIN;
        1:       value = VALUE_MAX;
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom;
      endcase
      add_word(op, value, 1'b0);
    end
    // pushes to a full queue, then one pop at each position
    add_word(OP_PUSH_FRONT, draw_value(), 1'b0);
    add_word(OP_PUSH_MID, draw_value(), 1'b0);
    add_word(OP_PUSH_BACK, draw_value(), 1'b0);
    add_word(OP_POP_FRONT, draw_value(), 1'b0);
    add_word(OP_POP_MID, draw_value(), 1'b0);
    add_word(OP_POP_BACK, draw_value(), 1'b0);

    push_pct = 50;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // vary the push/pop mix per segment so the fill swings between empty and full
      if (i % SEGMENT_LEN == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 15;
          1:       push_pct = 50;
          2:       push_pct = 85;
          default: push_pct = 100;
        endcase
        src_burst = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 3) op = OPCODE_W'($urandom_range(OP_UNUSED_A, OP_UNUSED_B));
      else if (r < push_pct) op = OPCODE_W'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK));
      else op = OPCODE_W'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
      add_word(op, draw_value(), (i == 0) || (i == RANDOM_WORDS / 2));
    end
    total = pend_words.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_sent < total || exp_results.size() > 0) @(negedge clk);
    repeat (4 * LATENCY) @(negedge clk);

    $display("Covered %0d words: %0d stored, %0d removed, %0d dropped full,",
             words_sent, n_push, n_pop, n_full_drop);
    $display("%0d empty pops, %0d no-ops, peak fill %0d of %0d, %0d results, %0d mismatches",
             n_empty_pop, n_noop, peak_fill, DEPTH, results_checked, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
